// ===== design/alle_pkg.sv =====
// Shared constants, codes and types of the array linked list engine.
`timescale 1ns / 1ps

package alle_pkg;

    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = 11;
    localparam int VALUE_W  = 32;
    localparam int TAG_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [TAG_W-1:0]   tag_t;

    localparam slot_t SLOT_ZERO = slot_t'(0);
    localparam slot_t SLOT_ONE  = slot_t'(1);
    localparam slot_t CAP_SLOT  = slot_t'(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 2'd0,
        CMD_DELETE     = 2'd1,
        CMD_READ_PHYS  = 2'd2,
        CMD_READ_LOGIC = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNAVAIL = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // One entry of the link memory.
    typedef struct packed {
        logic  used;
        slot_t prev;
        slot_t next;
    } link_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
        link_t data;
    } link_wr_t;

    typedef struct packed {
        logic   en;
        slot_t  addr;
        value_t value;
        tag_t   tag;
    } data_wr_t;

endpackage

// ===== design/alle_req_if.sv =====
// Request channel of the array linked list engine.
`timescale 1ns / 1ps

interface alle_req_if;

    logic                        valid;
    logic                        ready;
    logic [alle_pkg::CMD_W-1:0]  cmd;
    logic [alle_pkg::SLOT_W-1:0] position;
    logic [alle_pkg::VALUE_W-1:0] item_value;
    logic [alle_pkg::TAG_W-1:0]  item_tag;

    modport source (output valid, output cmd, output position, output item_value,
                    output item_tag, input ready);
    modport sink (input valid, input cmd, input position, input item_value,
                  input item_tag, output ready);

endinterface

// ===== design/alle_rsp_if.sv =====
// Result channel of the array linked list engine.
`timescale 1ns / 1ps

interface alle_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [alle_pkg::STATUS_W-1:0]  status;
    logic [alle_pkg::SLOT_W-1:0]    slot;
    logic [alle_pkg::VALUE_W-1:0]   read_value;
    logic [alle_pkg::TAG_W-1:0]     read_tag;

    modport source (output valid, output status, output slot, output read_value,
                    output read_tag, input ready);
    modport sink (input valid, input status, input slot, input read_value,
                  input read_tag, output ready);

endinterface

// ===== design/alle_link_mem.sv =====
// Link memory (used flag, backward and forward links) with a fill mark for reset state.
`timescale 1ns / 1ps

module alle_link_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  alle_pkg::slot_t    rd_addr,
    output alle_pkg::link_t    rd_data,
    input  alle_pkg::link_wr_t wr
);

    alle_pkg::link_t mem [0:alle_pkg::CAPACITY];

    alle_pkg::link_t raw_reg;
    alle_pkg::slot_t addr_reg;
    logic            fresh_hit_reg;
    alle_pkg::slot_t fresh_reg;
    alle_pkg::slot_t fresh_next;

    // Slots at or above the fill mark were never written since reset. They
    // still hold their reset contents: unused, no back link, chained to slot+1.
    always_comb
    begin
        fresh_next = fresh_reg;
        if (wr.en && (wr.addr == fresh_reg))
        begin
            fresh_next = fresh_reg + alle_pkg::SLOT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= alle_pkg::SLOT_ONE;
        end
        else
        begin
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        raw_reg       <= mem[rd_addr];
        addr_reg      <= rd_addr;
        fresh_hit_reg <= (rd_addr == alle_pkg::SLOT_ZERO) || (rd_addr >= fresh_reg);
    end

    always_comb
    begin
        if (fresh_hit_reg)
        begin
            rd_data.used = 1'b0;
            rd_data.prev = alle_pkg::SLOT_ZERO;
            rd_data.next = addr_reg + alle_pkg::SLOT_ONE;
        end
        else
        begin
            rd_data = raw_reg;
        end
    end

endmodule

// ===== design/alle_data_mem.sv =====
// Value and tag memory of the list slots.
`timescale 1ns / 1ps

module alle_data_mem (
    input  logic               clk,
    input  alle_pkg::slot_t    rd_addr,
    output alle_pkg::value_t   rd_value,
    output alle_pkg::tag_t     rd_tag,
    input  alle_pkg::data_wr_t wr
);

    alle_pkg::value_t value_mem [0:alle_pkg::CAPACITY];
    alle_pkg::tag_t   tag_mem   [0:alle_pkg::CAPACITY];

    alle_pkg::value_t value_reg;
    alle_pkg::tag_t   tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            value_mem[wr.addr] <= wr.value;
            tag_mem[wr.addr]   <= wr.tag;
        end
        value_reg <= value_mem[rd_addr];
        tag_reg   <= tag_mem[rd_addr];
    end

    assign rd_value = value_reg;
    assign rd_tag   = tag_reg;

endmodule

// ===== design/alle_ctrl.sv =====
// Command sequencer: list registers, read-modify-write steps and result register.
`timescale 1ns / 1ps

module alle_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    alle_req_if.sink            req,
    alle_rsp_if.source          rsp,
    output alle_pkg::slot_t     rd_addr,
    input  alle_pkg::link_t     link_rd,
    input  alle_pkg::value_t    data_rd_value,
    input  alle_pkg::tag_t      data_rd_tag,
    output alle_pkg::link_wr_t  link_wr,
    output alle_pkg::data_wr_t  data_wr
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD1   = 9'b000000010,
        S_RD2   = 9'b000000100,
        S_WR0   = 9'b000001000,
        S_WR1   = 9'b000010000,
        S_WR2   = 9'b000100000,
        S_WALK  = 9'b001000000,
        S_CHECK = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    alle_pkg::slot_t free_head_reg, free_head_next;
    alle_pkg::slot_t first_reg, first_next;
    alle_pkg::slot_t last_reg, last_next;
    alle_pkg::slot_t count_reg, count_next;
    logic            rsp_valid_reg, rsp_valid_next;

    alle_pkg::cmd_t   cmd_reg, cmd_next;
    alle_pkg::slot_t  pos_reg, pos_next;
    alle_pkg::value_t value_reg, value_next;
    alle_pkg::tag_t   tag_reg, tag_next;
    // a is the neighbor on the front side, b the one on the back side, and
    // center the slot that is taken or released.
    alle_pkg::slot_t  a_reg, a_next;
    alle_pkg::slot_t  b_reg, b_next;
    alle_pkg::slot_t  center_reg, center_next;
    alle_pkg::slot_t  a_back_reg, a_back_next;
    alle_pkg::slot_t  b_fwd_reg, b_fwd_next;
    alle_pkg::slot_t  fh_next_reg, fh_next_next;
    alle_pkg::slot_t  cur_reg, cur_next;
    alle_pkg::slot_t  walk_reg, walk_next;

    alle_pkg::status_t res_status_reg, res_status_next;
    alle_pkg::slot_t   res_slot_reg, res_slot_next;
    alle_pkg::value_t  res_value_reg, res_value_next;
    alle_pkg::tag_t    res_tag_reg, res_tag_next;

    alle_pkg::status_t out_status_reg, out_status_next;
    alle_pkg::slot_t   out_slot_reg, out_slot_next;
    alle_pkg::value_t  out_value_reg, out_value_next;
    alle_pkg::tag_t    out_tag_reg, out_tag_next;

    alle_pkg::cmd_t  req_cmd;
    logic            accept;
    alle_pkg::slot_t fwd_val;
    alle_pkg::slot_t back_val;

    assign req_cmd   = alle_pkg::cmd_t'(req.cmd);
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.read_tag   = out_tag_reg;

    // Insert links the new slot between a and b; delete links a to b directly.
    assign fwd_val  = (cmd_reg == alle_pkg::CMD_INSERT) ? center_reg : b_reg;
    assign back_val = (cmd_reg == alle_pkg::CMD_INSERT) ? center_reg : a_reg;

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        tag_next        = tag_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        center_next     = center_reg;
        a_back_next     = a_back_reg;
        b_fwd_next      = b_fwd_reg;
        fh_next_next    = fh_next_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        res_tag_next    = res_tag_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_value_next  = out_value_reg;
        out_tag_next    = out_tag_reg;
        rd_addr         = req.position;
        link_wr         = '0;
        data_wr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_cmd == alle_pkg::CMD_INSERT && count_reg == alle_pkg::SLOT_ZERO)
                begin
                    rd_addr = alle_pkg::SLOT_ZERO;
                end
                else if (req_cmd == alle_pkg::CMD_READ_LOGIC)
                begin
                    rd_addr = first_reg;
                end
                if (accept)
                begin
                    cmd_next        = req_cmd;
                    pos_next        = req.position;
                    value_next      = req.item_value;
                    tag_next        = req.item_tag;
                    res_status_next = alle_pkg::ST_OK;
                    res_slot_next   = req.position;
                    res_value_next  = '0;
                    res_tag_next    = '0;
                    cur_next        = rd_addr;
                    walk_next       = req.position - alle_pkg::SLOT_ONE;
                    if (req_cmd == alle_pkg::CMD_INSERT)
                    begin
                        if (req.position > alle_pkg::CAP_SLOT)
                        begin
                            res_status_next = alle_pkg::ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else if (count_reg >= alle_pkg::CAP_SLOT
                                 || free_head_reg == alle_pkg::SLOT_ZERO
                                 || free_head_reg > alle_pkg::CAP_SLOT)
                        begin
                            res_status_next = alle_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            a_next      = rd_addr;
                            center_next = free_head_reg;
                            state_next  = S_RD1;
                        end
                    end
                    else if (req.position == alle_pkg::SLOT_ZERO
                             || req.position > alle_pkg::CAP_SLOT)
                    begin
                        res_status_next = alle_pkg::ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        case (req_cmd)
                            alle_pkg::CMD_DELETE:
                            begin
                                state_next = S_RD1;
                            end
                            alle_pkg::CMD_READ_PHYS:
                            begin
                                state_next = S_CHECK;
                            end
                            alle_pkg::CMD_READ_LOGIC:
                            begin
                                if (req.position > count_reg)
                                begin
                                    res_status_next = alle_pkg::ST_UNAVAIL;
                                    state_next      = S_DONE;
                                end
                                else if (req.position == alle_pkg::SLOT_ONE)
                                begin
                                    state_next = S_CHECK;
                                end
                                else
                                begin
                                    state_next = S_WALK;
                                end
                            end
                            default:
                            begin
                                state_next = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_RD1:
            begin
                if (cmd_reg == alle_pkg::CMD_INSERT)
                begin
                    rd_addr = center_reg;
                    if (a_reg != alle_pkg::SLOT_ZERO && !link_rd.used)
                    begin
                        res_status_next = alle_pkg::ST_UNAVAIL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        a_back_next = link_rd.prev;
                        b_next      = (a_reg == alle_pkg::SLOT_ZERO) ? first_reg : link_rd.next;
                        state_next  = S_RD2;
                    end
                end
                else
                begin
                    rd_addr = link_rd.prev;
                    if (!link_rd.used)
                    begin
                        res_status_next = alle_pkg::ST_UNAVAIL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        a_next      = link_rd.prev;
                        b_next      = link_rd.next;
                        center_next = pos_reg;
                        state_next  = S_RD2;
                    end
                end
            end

            S_RD2:
            begin
                rd_addr = b_reg;
                if (cmd_reg == alle_pkg::CMD_INSERT)
                begin
                    fh_next_next = link_rd.next;
                end
                else
                begin
                    a_back_next = link_rd.prev;
                end
                state_next = S_WR0;
            end

            S_WR0:
            begin
                b_fwd_next   = link_rd.next;
                link_wr.en   = 1'b1;
                link_wr.addr = center_reg;
                if (cmd_reg == alle_pkg::CMD_INSERT)
                begin
                    link_wr.data.used = 1'b1;
                    link_wr.data.prev = a_reg;
                    link_wr.data.next = b_reg;
                    data_wr.en        = 1'b1;
                    data_wr.addr      = center_reg;
                    data_wr.value     = value_reg;
                    data_wr.tag       = tag_reg;
                    free_head_next    = fh_next_reg;
                    count_next        = count_reg + alle_pkg::SLOT_ONE;
                    res_slot_next     = center_reg;
                end
                else
                begin
                    link_wr.data.used = 1'b0;
                    link_wr.data.prev = alle_pkg::SLOT_ZERO;
                    link_wr.data.next = free_head_reg;
                    free_head_next    = center_reg;
                    count_next        = count_reg - alle_pkg::SLOT_ONE;
                end
                state_next = S_WR1;
            end

            S_WR1:
            begin
                if (a_reg != alle_pkg::SLOT_ZERO)
                begin
                    link_wr.en        = 1'b1;
                    link_wr.addr      = a_reg;
                    link_wr.data.used = 1'b1;
                    link_wr.data.prev = a_back_reg;
                    link_wr.data.next = fwd_val;
                end
                else
                begin
                    first_next = fwd_val;
                end
                state_next = S_WR2;
            end

            S_WR2:
            begin
                if (b_reg != alle_pkg::SLOT_ZERO)
                begin
                    link_wr.en        = 1'b1;
                    link_wr.addr      = b_reg;
                    link_wr.data.used = 1'b1;
                    link_wr.data.prev = back_val;
                    link_wr.data.next = b_fwd_reg;
                end
                else
                begin
                    last_next = back_val;
                end
                state_next = S_DONE;
            end

            S_WALK:
            begin
                // The forward link just read is the next address to fetch.
                rd_addr   = link_rd.next;
                cur_next  = link_rd.next;
                walk_next = walk_reg - alle_pkg::SLOT_ONE;
                if (walk_reg == alle_pkg::SLOT_ONE)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (cur_reg != alle_pkg::SLOT_ZERO && cur_reg <= alle_pkg::CAP_SLOT
                    && link_rd.used)
                begin
                    res_slot_next  = cur_reg;
                    res_value_next = data_rd_value;
                    res_tag_next   = data_rd_tag;
                end
                else
                begin
                    res_status_next = alle_pkg::ST_UNAVAIL;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_value_next  = res_value_reg;
                    out_tag_next    = res_tag_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= alle_pkg::SLOT_ONE;
            first_reg     <= alle_pkg::SLOT_ZERO;
            last_reg      <= alle_pkg::SLOT_ZERO;
            count_reg     <= alle_pkg::SLOT_ZERO;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        tag_reg        <= tag_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        center_reg     <= center_next;
        a_back_reg     <= a_back_next;
        b_fwd_reg      <= b_fwd_next;
        fh_next_reg    <= fh_next_next;
        cur_reg        <= cur_next;
        walk_reg       <= walk_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        res_tag_reg    <= res_tag_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_value_reg  <= out_value_next;
        out_tag_reg    <= out_tag_next;
    end

endmodule

// ===== design/array_linked_list_engine.sv =====
// Top level of the array linked list engine: sequencer and slot memories.
//
//   Channel  Direction  Fields
//   req      in         cmd, position, item_value, item_tag
//   rsp      out        status, slot, read_value, read_tag
//
// One request is worked at a time. Insert and delete go from accept to the result
// register through three link reads then up to three link writes on the single
// write port of the link memory. A physical read goes through S_CHECK, a logical
// read walks first, one link fetch per step of the walk; a request that fails its
// range, full or count check goes straight to S_DONE.
// After reset the engine takes requests at once: a fill mark stands in for the
// reset contents of the link memory, so there is no clearing pass.
// A result waits in the output register while the next request is accepted.
`timescale 1ns / 1ps

module array_linked_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    alle_req_if.sink   req,
    alle_rsp_if.source rsp
);

    alle_pkg::slot_t    rd_addr;
    alle_pkg::link_t    link_rd;
    alle_pkg::value_t   data_rd_value;
    alle_pkg::tag_t     data_rd_tag;
    alle_pkg::link_wr_t link_wr;
    alle_pkg::data_wr_t data_wr;

    alle_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .rd_addr       (rd_addr),
        .link_rd       (link_rd),
        .data_rd_value (data_rd_value),
        .data_rd_tag   (data_rd_tag),
        .link_wr       (link_wr),
        .data_wr       (data_wr)
    );

    alle_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (link_rd),
        .wr      (link_wr)
    );

    alle_data_mem u_data_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_value (data_rd_value),
        .rd_tag   (data_rd_tag),
        .wr       (data_wr)
    );

endmodule
